FILE: rtl/sks_pkg.sv
// Shared constants, codes and control structs for the sorted key set.
`timescale 1ns / 1ps

package sks_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_ENTRY     = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        VAL_KEY  = 2'd0,
        VAL_MEM  = 2'd1,
        VAL_ZERO = 2'd2
    } val_sel_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_START    = 3'd1,
        S_SCAN     = 3'd2,
        S_SHIFT    = 3'd3,
        S_REPLY    = 3'd4,
        S_LIST_RD  = 3'd5,
        S_LIST_OUT = 3'd6
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic     accept;
        logic     scan;
        logic     shift;
        logic     list_first;
        logic     list_next;
        logic     load_out;
        status_t  out_status;
        val_sel_t out_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic scan_done;
        logic present;
        logic full;
        logic shift_done;
        logic list_last;
        logic count_zero;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/sks_dpath.sv
// Datapath: key store memory, scan and shift cursors, count and output word register.
`timescale 1ns / 1ps

module sks_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sks_pkg::cmd_t                     cmd,
    output sks_pkg::stat_t                    stat,
    input  logic [1:0]                        op,
    input  logic signed [sks_pkg::KEY_W-1:0]  key,
    input  logic                              rsp_stall,
    output logic                              rsp_valid,
    output logic [2:0]                        status,
    output logic signed [sks_pkg::KEY_W-1:0]  value,
    output logic                              last
);

    localparam int IDX_W = sks_pkg::IDX_W;
    localparam int CNT_W = sks_pkg::CNT_W;
    localparam int KEY_W = sks_pkg::KEY_W;

    logic [KEY_W-1:0] mem [sks_pkg::CAPACITY];

    sks_pkg::op_t       op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   cur_reg;
    logic [CNT_W-1:0]   cur_next;
    logic [CNT_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic               rd_valid_reg;
    logic [KEY_W-1:0]   rdata_reg;
    logic               out_valid_reg;
    sks_pkg::status_t   out_status_reg;
    logic [KEY_W-1:0]   out_value_reg;
    logic               out_last_reg;

    logic               up;
    logic               hit;
    logic               scan_done;
    logic [CNT_W-1:0]   scan_pos;
    logic               sh_issue;
    logic               sh_done;
    logic               list_last;
    logic               out_free;
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [KEY_W-1:0]   wdata;

    assign up        = (op_reg == sks_pkg::OP_INSERT);
    // read data is compared in the cycle after its address went out
    assign hit       = rd_valid_reg && ($signed(rdata_reg) >= $signed(key_reg));
    assign scan_done = hit || (cur_reg == count_reg);
    assign scan_pos  = hit ? cur_reg - CNT_W'(1) : cur_reg;
    assign sh_issue  = up ? (cur_reg > pos_reg) : (cur_reg < count_reg);
    assign sh_done   = !sh_issue && !rd_valid_reg;
    assign list_last = (CNT_W'(rd_addr_reg) + CNT_W'(1)) == count_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        stat.op         = op_reg;
        stat.scan_done  = scan_done;
        stat.present    = hit && (rdata_reg == key_reg);
        stat.full       = (count_reg == CNT_W'(sks_pkg::CAPACITY));
        stat.shift_done = sh_done;
        stat.list_last  = list_last;
        stat.count_zero = (count_reg == '0);
        stat.out_free   = out_free;
    end

    // memory read port
    always_comb
    begin
        re    = 1'b0;
        raddr = '0;
        if (cmd.scan && !scan_done)
        begin
            re    = 1'b1;
            raddr = cur_reg[IDX_W-1:0];
        end
        else if (cmd.shift && sh_issue)
        begin
            re    = 1'b1;
            raddr = up ? IDX_W'(cur_reg - CNT_W'(1)) : cur_reg[IDX_W-1:0];
        end
        else if (cmd.list_first)
        begin
            re    = 1'b1;
            raddr = '0;
        end
        else if (cmd.list_next)
        begin
            re    = 1'b1;
            raddr = rd_addr_reg + IDX_W'(1);
        end
    end

    // memory write port: shifted entries, then the new key on insert
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = rdata_reg;
        if (cmd.shift)
        begin
            if (rd_valid_reg)
            begin
                we    = 1'b1;
                waddr = up ? rd_addr_reg + IDX_W'(1) : rd_addr_reg - IDX_W'(1);
            end
            else if (sh_done && up)
            begin
                we    = 1'b1;
                waddr = pos_reg[IDX_W-1:0];
                wdata = key_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg   <= mem[raddr];
            rd_addr_reg <= raddr;
        end
    end

    always_comb
    begin
        cur_next   = cur_reg;
        count_next = count_reg;
        if (cmd.accept)
        begin
            cur_next = '0;
        end
        else if (cmd.scan)
        begin
            if (scan_done)
            begin
                cur_next = up ? count_reg : scan_pos + CNT_W'(1);
            end
            else
            begin
                cur_next = cur_reg + CNT_W'(1);
            end
        end
        else if (cmd.shift)
        begin
            if (sh_issue)
            begin
                cur_next = up ? cur_reg - CNT_W'(1) : cur_reg + CNT_W'(1);
            end
            if (sh_done)
            begin
                count_next = up ? count_reg + CNT_W'(1) : count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_valid_reg <= re;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.accept)
        begin
            op_reg  <= sks_pkg::op_t'(op);
            key_reg <= key;
        end
        if (cmd.scan && scan_done)
        begin
            pos_reg <= scan_pos;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            out_last_reg   <= (cmd.out_sel == sks_pkg::VAL_MEM) ? list_last : 1'b1;
            case (cmd.out_sel)
                sks_pkg::VAL_KEY: out_value_reg <= key_reg;
                sks_pkg::VAL_MEM: out_value_reg <= rdata_reg;
                default:          out_value_reg <= '0;
            endcase
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign value     = out_value_reg;
    assign last      = out_last_reg;

endmodule

FILE: rtl/sks_ctrl.sv
// Controller: sequences accept, scan, shift, reply and list for one word at a time.
`timescale 1ns / 1ps

module sks_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sks_pkg::stat_t  stat,
    output sks_pkg::cmd_t   cmd
);

    sks_pkg::state_t  state_reg;
    sks_pkg::state_t  state_next;
    sks_pkg::status_t reply_reg;
    sks_pkg::status_t reply_next;

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        unique case (state_reg)
            sks_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sks_pkg::S_START;
                end
            end
            sks_pkg::S_START:
            begin
                if (stat.op == sks_pkg::OP_LIST)
                begin
                    if (stat.count_zero)
                    begin
                        state_next = sks_pkg::S_REPLY;
                        reply_next = sks_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        state_next = sks_pkg::S_LIST_RD;
                    end
                end
                else
                begin
                    state_next = sks_pkg::S_SCAN;
                end
            end
            sks_pkg::S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = sks_pkg::S_REPLY;
                    unique case (stat.op)
                        sks_pkg::OP_INSERT:
                        begin
                            if (stat.present)
                            begin
                                reply_next = sks_pkg::ST_DUPLICATE;
                            end
                            else if (stat.full)
                            begin
                                reply_next = sks_pkg::ST_FULL;
                            end
                            else
                            begin
                                reply_next = sks_pkg::ST_DONE;
                                state_next = sks_pkg::S_SHIFT;
                            end
                        end
                        sks_pkg::OP_REMOVE:
                        begin
                            if (stat.present)
                            begin
                                reply_next = sks_pkg::ST_DONE;
                                state_next = sks_pkg::S_SHIFT;
                            end
                            else
                            begin
                                reply_next = sks_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            reply_next = stat.present ? sks_pkg::ST_FOUND
                                                      : sks_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            sks_pkg::S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = sks_pkg::S_REPLY;
                end
            end
            sks_pkg::S_REPLY:
            begin
                if (stat.out_free)
                begin
                    state_next = sks_pkg::S_IDLE;
                end
            end
            sks_pkg::S_LIST_RD:
            begin
                state_next = sks_pkg::S_LIST_OUT;
            end
            sks_pkg::S_LIST_OUT:
            begin
                if (stat.out_free && stat.list_last)
                begin
                    state_next = sks_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sks_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.out_status = reply_reg;
        cmd.out_sel    = sks_pkg::VAL_KEY;
        req_stall      = 1'b1;
        unique case (state_reg)
            sks_pkg::S_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            sks_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            sks_pkg::S_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            sks_pkg::S_REPLY:
            begin
                cmd.load_out = stat.out_free;
                cmd.out_sel  = (reply_reg == sks_pkg::ST_EMPTY) ? sks_pkg::VAL_ZERO
                                                                : sks_pkg::VAL_KEY;
            end
            sks_pkg::S_LIST_RD:
            begin
                cmd.list_first = 1'b1;
            end
            sks_pkg::S_LIST_OUT:
            begin
                // read data holds while the output word is stalled
                cmd.load_out   = stat.out_free;
                cmd.out_status = sks_pkg::ST_ENTRY;
                cmd.out_sel    = sks_pkg::VAL_MEM;
                cmd.list_next  = stat.out_free && !stat.list_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sks_pkg::S_IDLE;
            reply_reg <= sks_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

endmodule

FILE: rtl/sorted_key_set.sv
// Top level of the sorted key set: controller plus datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------
//  request  | req_valid / req_stall | op, key
//  response | rsp_valid / rsp_stall | status, value, last
//
// One request word at a time. Insert, remove and search scan the stored keys
// through the single registered memory read port up to the first key not below
// the key; a successful insert or remove then shifts the keys behind it, and a
// reply follows. List reads ahead, then gives one word per cycle unless stalled.
// Reset empties the set at once; stored keys stay undefined until written.
// A stalled response word is held; a new request is taken once the last word
// of the current one sits in the output register.
`timescale 1ns / 1ps

module sorted_key_set
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        op,
    input  logic signed [sks_pkg::KEY_W-1:0]  key,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [2:0]                        status,
    output logic signed [sks_pkg::KEY_W-1:0]  value,
    output logic                              last
);

    sks_pkg::cmd_t  cmd;
    sks_pkg::stat_t stat;

    sks_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sks_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op        (op),
        .key       (key),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .status    (status),
        .value     (value),
        .last      (last)
    );

endmodule
